[hdl/prl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

   // Default sizes of the request table.
   localparam int TABLE_DEPTH_DEF  = 16;
   localparam int COOKIE_BYTES_DEF = 4;

   // Operation codes carried in the kind field.
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_DUPLICATE  = 3'd1;
   localparam logic [2:0] STATUS_FULL       = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND  = 3'd3;
   localparam logic [2:0] STATUS_SLOT_EMPTY = 3'd4;

   // How the result word is filled beyond its status.
   localparam logic [1:0] RES_PLAIN  = 2'd0;
   localparam logic [1:0] RES_ADD    = 2'd1;
   localparam logic [1:0] RES_LOOKUP = 2'd2;

   // One request word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] cookie;
      logic [31:0] peer_address;
      logic [15:0] command;
      logic [3:0]  slot;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  found_slot;
      logic [31:0] found_address;
      logic [15:0] found_command;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       walk_first;
      logic       walk_next;
      logic       add_link;
      logic       add_write;
      logic       rem_unlink;
      logic       finish;
      logic [2:0] status;
      logic [1:0] res_kind;
   } prl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] kind;
      logic       head_null;
      logic       hit;
      logic       walk_end;
      logic       scan_done;
      logic       table_full;
      logic       slot_bad;
   } prl_stat_type;

endpackage

`default_nettype wire

[hdl/prl_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module prl_datapath import prl_pkg::*; #(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int COOKIE_BYTES = COOKIE_BYTES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req_word,
   input  wire prl_cmd_type  cmd,
   output prl_stat_type      stat,
   output logic              rsp_valid,
   output rsp_type           rsp_word
);

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int LINK_W   = $clog2(TABLE_DEPTH + 1);
   localparam int COOKIE_W = (COOKIE_BYTES * 8 < 32) ? COOKIE_BYTES * 8 : 32;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(TABLE_DEPTH);

   // Request latched at acceptance.
   req_type req_ff;

   // Slot occupancy and list ends.
   logic [TABLE_DEPTH-1:0] used_ff;
   logic [LINK_W-1:0]      head_ff;
   logic [LINK_W-1:0]      tail_ff;

   // Walk position, visit count and free slot scan.
   logic [LINK_W-1:0] cur_ff;
   logic [LINK_W-1:0] steps_ff;
   logic [LINK_W-1:0] scan_ff;

   // Table memories and their registered read data.
   logic [COOKIE_W-1:0] cookie_mem  [TABLE_DEPTH];
   logic [31:0]         address_mem [TABLE_DEPTH];
   logic [15:0]         command_mem [TABLE_DEPTH];
   logic [LINK_W-1:0]   next_mem    [TABLE_DEPTH];
   logic [LINK_W-1:0]   prev_mem    [TABLE_DEPTH];

   logic [COOKIE_W-1:0] rd_cookie_ff;
   logic [31:0]         rd_address_ff;
   logic [15:0]         rd_command_ff;
   logic [LINK_W-1:0]   rd_next_ff;
   logic [LINK_W-1:0]   rd_prev_ff;

   rsp_type rsp_word_ff;
   rsp_type rsp_word_in;
   logic    rsp_valid_ff;

   logic [COOKIE_W-1:0] key;
   logic [IDX_W-1:0]    slot_idx;
   logic [LINK_W-1:0]   slot_link;
   logic [IDX_W-1:0]    free_idx;
   logic [LINK_W-1:0]   free_link;
   logic [IDX_W-1:0]    cur_idx;
   logic [IDX_W-1:0]    rd_idx;
   logic                scan_full;
   logic                scan_done;
   logic                prev_valid;
   logic                next_valid;

   logic                next_we;
   logic [IDX_W-1:0]    next_waddr;
   logic [LINK_W-1:0]   next_wdata;
   logic                prev_we;
   logic [IDX_W-1:0]    prev_waddr;
   logic [LINK_W-1:0]   prev_wdata;

   // Derived indexes and flags.
   assign key        = req_ff.cookie[COOKIE_W-1:0];
   assign slot_idx   = IDX_W'(req_ff.slot);
   assign slot_link  = LINK_W'(slot_idx);
   assign free_idx   = scan_ff[IDX_W-1:0];
   assign free_link  = LINK_W'(free_idx);
   assign cur_idx    = cur_ff[IDX_W-1:0];
   assign scan_full  = (scan_ff == NIL);
   assign scan_done  = scan_full || !used_ff[free_idx];
   assign prev_valid = (rd_prev_ff < NIL);
   assign next_valid = (rd_next_ff < NIL);

   // Status toward the controller.
   always_comb begin
      stat.kind       = req_ff.kind;
      stat.head_null  = (head_ff >= NIL);
      stat.hit        = used_ff[cur_idx] && (rd_cookie_ff == key);
      stat.walk_end   = (rd_next_ff >= NIL) || (steps_ff == NIL);
      stat.scan_done  = scan_done;
      stat.table_full = scan_full;
      stat.slot_bad   = (32'(req_ff.slot) >= 32'(TABLE_DEPTH)) || !used_ff[slot_idx];
   end

   // Read address: list head, the link just read, or the slot to remove.
   always_comb begin
      if (cmd.walk_first) begin
         rd_idx = head_ff[IDX_W-1:0];
      end else if (cmd.walk_next) begin
         rd_idx = rd_next_ff[IDX_W-1:0];
      end else begin
         rd_idx = slot_idx;
      end
   end

   // Write port of the forward links.
   always_comb begin
      next_we    = 1'b0;
      next_waddr = free_idx;
      next_wdata = NIL;
      if (cmd.add_link) begin
         next_we    = (tail_ff < NIL);
         next_waddr = tail_ff[IDX_W-1:0];
         next_wdata = free_link;
      end else if (cmd.add_write) begin
         next_we    = 1'b1;
      end else if (cmd.rem_unlink) begin
         next_we    = prev_valid;
         next_waddr = rd_prev_ff[IDX_W-1:0];
         next_wdata = rd_next_ff;
      end
   end

   // Write port of the backward links.
   always_comb begin
      prev_we    = 1'b0;
      prev_waddr = free_idx;
      prev_wdata = tail_ff;
      if (cmd.add_write) begin
         prev_we    = 1'b1;
      end else if (cmd.rem_unlink) begin
         prev_we    = next_valid;
         prev_waddr = rd_next_ff[IDX_W-1:0];
         prev_wdata = rd_prev_ff;
      end
   end

   // Table memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         cookie_mem[free_idx]  <= key;
         address_mem[free_idx] <= req_ff.peer_address;
         command_mem[free_idx] <= req_ff.command;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      rd_cookie_ff  <= cookie_mem[rd_idx];
      rd_address_ff <= address_mem[rd_idx];
      rd_command_ff <= command_mem[rd_idx];
      rd_next_ff    <= next_mem[rd_idx];
      rd_prev_ff    <= prev_mem[rd_idx];
   end

   // Request latch, walk position and free slot scan.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.walk_first) begin
         cur_ff   <= head_ff;
         steps_ff <= LINK_W'(1);
      end else if (cmd.walk_next) begin
         cur_ff   <= rd_next_ff;
         steps_ff <= steps_ff + LINK_W'(1);
      end
      if (cmd.load) begin
         scan_ff <= '0;
      end else if (!scan_done) begin
         scan_ff <= scan_ff + LINK_W'(1);
      end
   end

   // Occupancy and list ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         head_ff <= NIL;
         tail_ff <= NIL;
      end else if (cmd.add_write) begin
         used_ff[free_idx] <= 1'b1;
         tail_ff           <= free_link;
         if (tail_ff >= NIL) begin
            head_ff <= free_link;
         end
      end else if (cmd.rem_unlink) begin
         used_ff[slot_idx] <= 1'b0;
         if (head_ff == slot_link) begin
            head_ff <= rd_next_ff;
         end
         if (tail_ff == slot_link) begin
            tail_ff <= rd_prev_ff;
         end
      end
   end

   // Next result word: status plus the fields its kind fills in.
   always_comb begin
      rsp_word_in        = '0;
      rsp_word_in.status = cmd.status;
      case (cmd.res_kind)
         RES_ADD: begin
            rsp_word_in.found_slot = 4'(free_idx);
         end
         RES_LOOKUP: begin
            rsp_word_in.found_slot    = 4'(cur_idx);
            rsp_word_in.found_address = rd_address_ff;
            rsp_word_in.found_command = rd_command_ff;
         end
         default: begin
         end
      endcase
   end

   // Result word, shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

[hdl/prl_controller.sv]
`timescale 1ns / 1ps
`default_nettype none

module prl_controller import prl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire prl_stat_type  stat,
   output prl_cmd_type        cmd,
   output logic               busy
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_DISPATCH   = 3'd1;
   localparam logic [2:0] ST_WALK       = 3'd2;
   localparam logic [2:0] ST_ADD_WAIT   = 3'd3;
   localparam logic [2:0] ST_ADD_LINK   = 3'd4;
   localparam logic [2:0] ST_ADD_WRITE  = 3'd5;
   localparam logic [2:0] ST_REM_UNLINK = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.kind)
               KIND_ADD: begin
                  if (stat.head_null) begin
                     state_in = ST_ADD_WAIT;
                  end else begin
                     cmd.walk_first = 1'b1;
                     state_in       = ST_WALK;
                  end
               end
               KIND_LOOKUP: begin
                  if (stat.head_null) begin
                     cmd.finish = 1'b1;
                     cmd.status = STATUS_NOT_FOUND;
                     state_in   = ST_IDLE;
                  end else begin
                     cmd.walk_first = 1'b1;
                     state_in       = ST_WALK;
                  end
               end
               KIND_REMOVE: begin
                  if (stat.slot_bad) begin
                     cmd.finish = 1'b1;
                     cmd.status = STATUS_SLOT_EMPTY;
                     state_in   = ST_IDLE;
                  end else begin
                     // The read address defaults to the slot, so its links arrive next.
                     state_in = ST_REM_UNLINK;
                  end
               end
               default: begin
                  // The unused kind gives a plain ok result.
                  cmd.finish = 1'b1;
                  cmd.status = STATUS_OK;
                  state_in   = ST_IDLE;
               end
            endcase
         end
         ST_WALK: begin
            if (stat.hit) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
               if (stat.kind == KIND_ADD) begin
                  cmd.status = STATUS_DUPLICATE;
               end else begin
                  cmd.status   = STATUS_OK;
                  cmd.res_kind = RES_LOOKUP;
               end
            end else if (stat.walk_end) begin
               if (stat.kind == KIND_ADD) begin
                  state_in = ST_ADD_WAIT;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.status = STATUS_NOT_FOUND;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         ST_ADD_WAIT: begin
            if (stat.scan_done) begin
               if (stat.table_full) begin
                  cmd.finish = 1'b1;
                  cmd.status = STATUS_FULL;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_ADD_LINK;
               end
            end
         end
         ST_ADD_LINK: begin
            cmd.add_link = 1'b1;
            state_in     = ST_ADD_WRITE;
         end
         ST_ADD_WRITE: begin
            cmd.add_write = 1'b1;
            cmd.finish    = 1'b1;
            cmd.status    = STATUS_OK;
            cmd.res_kind  = RES_ADD;
            state_in      = ST_IDLE;
         end
         ST_REM_UNLINK: begin
            cmd.rem_unlink = 1'b1;
            cmd.finish     = 1'b1;
            cmd.status     = STATUS_OK;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[hdl/pending_request_list.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                      Transfer
// request    start, busy, req_word      taken at an edge with start high and busy low
// result     rsp_valid, rsp_word        one cycle strobe, taken at the edge ending it
//
// A new add walks every listed entry before it writes; with a full table it ends after
// the walk; a duplicate add and a lookup stop at the entry they match. The walk visits
// one entry a cycle; a remove unlinks after dispatch, a free slot or unused kind ends there.
// The result shows in the same cycle that busy falls; a new word may start then.
// Reset clears occupancy, list ends and control at once; no clearing pass.
// The receiver cannot stall results.

module pending_request_list import prl_pkg::*; #(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int COOKIE_BYTES = COOKIE_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_word,
   output logic         rsp_valid,
   output rsp_type      rsp_word
);

   prl_cmd_type  cmd;
   prl_stat_type stat;

   // Sequencer.
   prl_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Tables, links and result register.
   prl_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .COOKIE_BYTES (COOKIE_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

[hdl/prl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module prl_checker import prl_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire rsp_type rsp_word,
   input wire logic    rsp_valid
);

   // An accepted word makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // A result only appears while the block is idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // Busy ends only together with a result.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy fell without a result");

   // Result strobes never come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // Status codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status <= STATUS_SLOT_EMPTY)
      else $error("undefined status code");

endmodule

bind pending_request_list prl_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_word  (rsp_word),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
